>>> hdl/stack_trace_sample_tally_top_macros.svh
// Assertion helpers for the tally block.
`ifndef STACK_TRACE_SAMPLE_TALLY_TOP_MACROS_SVH
`define STACK_TRACE_SAMPLE_TALLY_TOP_MACROS_SVH
`define STST_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define STST_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

>>> hdl/stst_pkg.sv
`timescale 1ns / 1ps
package stst_pkg;
   localparam logic [1:0] CMD_FRAME = 2'd0;
   localparam logic [1:0] CMD_FAIL  = 2'd1;
   localparam logic [1:0] CMD_RDENT = 2'd2;
   localparam logic [1:0] CMD_RDCNT = 2'd3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_COUNTED  = 3'd1;
   localparam logic [2:0] ST_DROPPED  = 3'd2;
   localparam logic [2:0] ST_IGNORED  = 3'd3;
   localparam logic [2:0] ST_ENTRY    = 3'd4;
   localparam logic [2:0] ST_COUNTER  = 3'd5;
   localparam logic [2:0] ST_FAILONLY = 3'd6;

   typedef struct packed {
      logic cap;       // capture request
      logic frame;     // store/hash frame
      logic fin;       // finalise hash, set probe start
      logic rd_slot;   // issue slot/entry memory reads
      logic rd_frame;  // issue stored/pending frame reads
      logic fr_next;   // advance frame compare index
      logic probe_next;// move to next slot
      logic wr_new;    // write new slot header
      logic cp_frame;  // copy one frame
      logic wr_inc;    // raise slot count
      logic fail_inc;  // bump failure counter
      logic out_tally; // emit tally result
      logic out_drop;
      logic out_misc;  // report/read results
      logic clr_pend;
   } ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       last;
      logic       beyond;   // frame past limit
      logic       code_big;
      logic       code_zero;
      logic       slot_empty;
      logic       len_eq;
      logic       fr_done;  // all frames compared/copied
      logic       fr_eq;
      logic       probe_done;
      logic       clr_done;
   } sts_type;
endpackage

>>> hdl/stack_trace_sample_tally_top.sv
`timescale 1ns / 1ps
// Trace tally. Pulse start with busy low to give a request; results come as a one-cycle
// rsp_valid strobe that cannot be stalled. A frame that does not end a trace is stored
// and hashed unless past MAX_FRAMES; a trace end or error report hashes then probes
// the table linearly, comparing the stored frames of each slot visited, and copies
// the frames into an empty slot. Reads, and reports that tally no trace, skip the probe.
// After reset the count memory is cleared while busy stays high.
module stack_trace_sample_tally_top #(
   parameter int TRACE_SLOTS = 1024,
   parameter int MAX_FRAMES = 64,
   parameter int NUM_ERROR_CODES = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [63:0]        req_method_id,
   input  logic signed [31:0] req_line_number,
   input  logic               req_last_frame,
   input  logic [7:0]         req_code,
   input  logic [9:0]         req_slot,
   input  logic [5:0]         req_frame_index,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [9:0]         rsp_slot_used,
   output logic [31:0]        rsp_count,
   output logic signed [7:0]  rsp_frame_count,
   output logic [63:0]        rsp_frame_method,
   output logic signed [31:0] rsp_frame_line
);
   stst_pkg::ctl_type ctl;
   stst_pkg::sts_type sts;

   stst_ctrl u_ctrl (.clock, .reset, .start, .sts, .busy, .ctl);
   stst_dp #(.TRACE_SLOTS(TRACE_SLOTS), .MAX_FRAMES(MAX_FRAMES),
             .NUM_ERROR_CODES(NUM_ERROR_CODES)) u_dp (
      .clock, .reset, .ctl, .sts, .req_command, .req_method_id, .req_line_number,
      .req_last_frame, .req_code, .req_slot, .req_frame_index, .rsp_valid, .rsp_status,
      .rsp_slot_used, .rsp_count, .rsp_frame_count, .rsp_frame_method, .rsp_frame_line);
endmodule

>>> hdl/stst_ram.sv
`timescale 1ns / 1ps
module stst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

>>> hdl/stst_ctrl.sv
`timescale 1ns / 1ps
`include "stack_trace_sample_tally_top_macros.svh"
module stst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  stst_pkg::sts_type sts,
   output logic              busy,
   output stst_pkg::ctl_type ctl
);
   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_DEC = 4'd2, S_FIN = 4'd3,
      S_RDS = 4'd4, S_CHK = 4'd5, S_RDF = 4'd6, S_CMP = 4'd7, S_CPY = 4'd8,
      S_DONE = 4'd9, S_MISC = 4'd10, S_MWAIT = 4'd11;
   logic [3:0] state_ff, state_in;

   assign busy = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      unique case (state_ff)
         S_CLR: if (sts.clr_done) state_in = S_IDLE;
         S_IDLE: begin
            if (start) begin
               ctl.cap = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.cmd == stst_pkg::CMD_FRAME) begin
               ctl.frame = !sts.beyond;
               state_in = sts.last ? S_FIN : S_IDLE;
            end else if (sts.cmd == stst_pkg::CMD_FAIL && !sts.code_big &&
                         !sts.code_zero) begin
               ctl.fail_inc = 1'b1;
               state_in = S_FIN;
            end else begin
               ctl.fail_inc = sts.cmd == stst_pkg::CMD_FAIL && !sts.code_big;
               ctl.rd_slot = 1'b1;
               state_in = S_MWAIT;
            end
         end
         S_MWAIT: state_in = S_MISC;
         S_MISC: begin
            ctl.out_misc = 1'b1;
            state_in = S_IDLE;
         end
         S_FIN: begin
            ctl.fin = 1'b1;
            state_in = S_RDS;
         end
         S_RDS: begin
            ctl.rd_slot = 1'b1;
            ctl.rd_frame = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.slot_empty) begin
               ctl.wr_new = 1'b1;
               state_in = S_CPY;
            end else if (sts.len_eq) state_in = S_CMP;
            else if (sts.probe_done) begin
               ctl.out_drop = 1'b1;
               ctl.clr_pend = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctl.probe_next = 1'b1;
               state_in = S_RDS;
            end
         end
         S_CMP: begin
            if (sts.fr_done) begin
               ctl.wr_inc = 1'b1;
               state_in = S_DONE;
            end else if (!sts.fr_eq) begin
               if (sts.probe_done) begin
                  ctl.out_drop = 1'b1;
                  ctl.clr_pend = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  ctl.probe_next = 1'b1;
                  state_in = S_RDS;
               end
            end else begin
               ctl.fr_next = 1'b1;
               state_in = S_RDF;
            end
         end
         S_RDF: begin
            ctl.rd_frame = 1'b1;
            state_in = S_CMP;
         end
         S_CPY: begin
            if (sts.fr_done) state_in = S_DONE;
            else ctl.cp_frame = 1'b1;
         end
         S_DONE: begin
            ctl.out_tally = 1'b1;
            ctl.clr_pend = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLR;
      else state_ff <= state_in;
   end

   `STST_ASSERT_IMP(a_cap_idle, clock, reset, ctl.cap, state_ff == S_IDLE)
   `STST_ASSERT_IMP(a_one_out, clock, reset, ctl.out_tally,
                    !ctl.out_drop && !ctl.out_misc)
   `STST_ASSERT_NXT(a_back_idle, clock, reset, ctl.out_misc, !busy)
endmodule

>>> hdl/stst_dp.sv
`timescale 1ns / 1ps
module stst_dp #(
   parameter int TRACE_SLOTS = 1024,
   parameter int MAX_FRAMES = 64,
   parameter int NUM_ERROR_CODES = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stst_pkg::ctl_type        ctl,
   output stst_pkg::sts_type        sts,
   input  logic [1:0]               req_command,
   input  logic [63:0]              req_method_id,
   input  logic signed [31:0]       req_line_number,
   input  logic                     req_last_frame,
   input  logic [7:0]               req_code,
   input  logic [9:0]               req_slot,
   input  logic [5:0]               req_frame_index,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_status,
   output logic [9:0]               rsp_slot_used,
   output logic [31:0]              rsp_count,
   output logic signed [7:0]        rsp_frame_count,
   output logic [63:0]              rsp_frame_method,
   output logic signed [31:0]       rsp_frame_line
);
   localparam int SW = (TRACE_SLOTS > 1) ? $clog2(TRACE_SLOTS) : 1;
   localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int LW = $clog2(MAX_FRAMES + 1);
   localparam int AW = SW + FW;
   localparam int CW = $clog2(NUM_ERROR_CODES + 1);
   localparam logic [31:0] CMAX = '1;

   logic [1:0]  cmd_ff;
   logic [63:0] meth_ff;
   logic [31:0] line_ff;
   logic        last_ff;
   logic [7:0]  code_ff;
   logic [9:0]  rslot_ff;
   logic [5:0]  fidx_ff;
   logic [LW-1:0] plen_ff;
   logic [63:0] hash_ff, h1, h2, h3, hf;
   logic [SW-1:0] pslot_ff, pslot_in;
   logic [SW:0]   ntry_ff;
   logic [LW-1:0] fi_ff;
   logic signed [7:0] tlen_ff;
   logic [SW:0] clr_ff;
   logic [31:0] fcnt_ff [NUM_ERROR_CODES + 1];

   logic cnt_we, len_we, st_we;
   logic [SW-1:0] cnt_wa, cnt_ra;
   logic [31:0] cnt_wd, cnt_rd;
   logic [7:0] len_rd;
   logic [AW-1:0] st_wa, st_ra;
   logic [95:0] st_rd, pd_rd;
   logic [FW-1:0] pd_ra;
   logic [7:0] tlen_in;

   logic code_big;
   logic cnt_st_new_ff, cnt_st_new;
   logic [2:0]  mx_st;
   logic [9:0]  mx_slot;
   logic [31:0] mx_cnt;
   logic [7:0]  mx_len;
   logic [63:0] mx_meth;
   logic [31:0] mx_line;

   always_comb begin
      h1 = hash_ff + meth_ff;
      h1 = h1 + (h1 << 10);
      h1 = h1 ^ (h1 >> 6);
   end
   always_comb begin
      h2 = h1 + {{32{line_ff[31]}}, line_ff};
      h2 = h2 + (h2 << 10);
      h2 = h2 ^ (h2 >> 6);
   end
   always_comb begin
      h3 = ((cmd_ff == stst_pkg::CMD_FRAME) ? hash_ff : 64'd0);
      h3 = h3 + (h3 << 3);
      hf = h3 ^ (h3 >> 11);
   end

   assign tlen_in = (cmd_ff == stst_pkg::CMD_FRAME) ? 8'(plen_ff) : -8'(code_ff);

   stst_ram #(.WIDTH(32), .DEPTH(1 << SW)) u_cnt (.clock, .we(cnt_we), .waddr(cnt_wa),
      .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
   stst_ram #(.WIDTH(8), .DEPTH(1 << SW)) u_len (.clock, .we(len_we), .waddr(pslot_ff),
      .wdata(tlen_ff), .raddr(cnt_ra), .rdata(len_rd));
   stst_ram #(.WIDTH(96), .DEPTH(1 << AW)) u_st (.clock, .we(st_we), .waddr(st_wa),
      .wdata(pd_rd), .raddr(st_ra), .rdata(st_rd));
   stst_ram #(.WIDTH(96), .DEPTH(1 << FW)) u_pd (.clock, .we(ctl.frame),
      .waddr(FW'(plen_ff)), .wdata({meth_ff, line_ff}), .raddr(pd_ra), .rdata(pd_rd));

   logic clearing;
   assign clearing = !clr_ff[SW];
   logic rd_sel;
   assign rd_sel = (cmd_ff == stst_pkg::CMD_RDENT);
   logic [LW-1:0] fi_nx;
   assign fi_nx = ctl.fr_next ? fi_ff + 1'b1 : fi_ff;

   always_comb begin
      cnt_ra = rd_sel ? SW'(rslot_ff) : pslot_ff;
      pd_ra = FW'(ctl.cp_frame ? fi_ff + 1'b1 : fi_nx);
      st_ra = rd_sel ? {SW'(rslot_ff), FW'(fidx_ff)} : {pslot_ff, FW'(fi_nx)};
      st_wa = {pslot_ff, FW'(fi_ff)};
      st_we = ctl.cp_frame;
      len_we = ctl.wr_new;
      cnt_we = clearing || ctl.wr_new || ctl.wr_inc;
      cnt_wa = clearing ? SW'(clr_ff) : pslot_ff;
      cnt_wd = clearing ? 32'd0 : ctl.wr_new ? 32'd1 :
               (cnt_rd == CMAX) ? cnt_rd : cnt_rd + 32'd1;
      pslot_in = (32'(pslot_ff) == TRACE_SLOTS - 1) ? '0 : pslot_ff + 1'b1;
   end

   always_comb begin
      mx_st = stst_pkg::ST_ENTRY;
      mx_slot = '0;
      mx_cnt = '0;
      mx_len = '0;
      mx_meth = '0;
      mx_line = '0;
      if (code_big && cmd_ff != stst_pkg::CMD_RDENT) mx_st = stst_pkg::ST_IGNORED;
      else if (cmd_ff == stst_pkg::CMD_FAIL) begin
         mx_st = stst_pkg::ST_FAILONLY;
         mx_cnt = fcnt_ff[0];
      end else if (cmd_ff == stst_pkg::CMD_RDCNT) begin
         mx_st = stst_pkg::ST_COUNTER;
         mx_cnt = fcnt_ff[CW'(code_ff)];
      end else begin
         mx_slot = rslot_ff;
         if (32'(rslot_ff) < TRACE_SLOTS && cnt_rd != 0) begin
            mx_cnt = cnt_rd;
            mx_len = len_rd;
            if (!len_rd[7] && {2'b0, fidx_ff} < len_rd && 32'(fidx_ff) < MAX_FRAMES) begin
               mx_meth = st_rd[95:32];
               mx_line = st_rd[31:0];
            end
         end
      end
   end

   logic [31:0] newcnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         plen_ff <= '0;
         hash_ff <= '0;
         rsp_valid <= 1'b0;
         for (int i = 0; i <= NUM_ERROR_CODES; i++) fcnt_ff[i] <= '0;
      end else begin
         if (clearing) clr_ff <= (32'(clr_ff) == TRACE_SLOTS - 1) ? {1'b1, SW'(0)} :
                                 clr_ff + 1'b1;
         rsp_valid <= ctl.out_tally || ctl.out_drop || ctl.out_misc;
         if (ctl.frame) begin
            plen_ff <= plen_ff + 1'b1;
            hash_ff <= h2;
         end
         if (ctl.clr_pend && cmd_ff == stst_pkg::CMD_FRAME) begin
            plen_ff <= '0;
            hash_ff <= '0;
         end
         if (ctl.fail_inc && fcnt_ff[CW'(code_ff)] != CMAX)
            fcnt_ff[CW'(code_ff)] <= fcnt_ff[CW'(code_ff)] + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cap) begin
         cmd_ff <= req_command;
         meth_ff <= req_method_id;
         line_ff <= req_line_number;
         last_ff <= req_last_frame;
         code_ff <= req_code;
         rslot_ff <= req_slot;
         fidx_ff <= req_frame_index;
      end
      if (ctl.fin) begin
         pslot_ff <= SW'(hf % TRACE_SLOTS);
         ntry_ff <= '0;
         tlen_ff <= tlen_in;
      end
      if (ctl.probe_next) begin
         pslot_ff <= pslot_in;
         ntry_ff <= ntry_ff + 1'b1;
      end
      if (ctl.rd_slot) fi_ff <= '0;
      if (ctl.fr_next || ctl.cp_frame) fi_ff <= fi_ff + 1'b1;
      if (ctl.wr_new || ctl.wr_inc) newcnt_ff <= cnt_wd;
      if (ctl.out_tally) begin
         rsp_status <= ctl.out_tally && cnt_st_new ? stst_pkg::ST_INSERTED :
                       stst_pkg::ST_COUNTED;
         rsp_slot_used <= 10'(pslot_ff);
         rsp_count <= newcnt_ff;
         rsp_frame_count <= tlen_ff;
         rsp_frame_method <= '0;
         rsp_frame_line <= '0;
      end else if (ctl.out_drop) begin
         rsp_status <= stst_pkg::ST_DROPPED;
         rsp_slot_used <= '0;
         rsp_count <= '0;
         rsp_frame_count <= tlen_ff;
         rsp_frame_method <= '0;
         rsp_frame_line <= '0;
      end else if (ctl.out_misc) begin
         rsp_status <= mx_st;
         rsp_slot_used <= mx_slot;
         rsp_count <= mx_cnt;
         rsp_frame_count <= mx_len;
         rsp_frame_method <= mx_meth;
         rsp_frame_line <= mx_line;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_new) cnt_st_new_ff <= 1'b1;
      else if (ctl.wr_inc) cnt_st_new_ff <= 1'b0;
   end
   assign cnt_st_new = cnt_st_new_ff;

   assign code_big = 32'(code_ff) > NUM_ERROR_CODES;
   logic [LW-1:0] nf;
   assign nf = tlen_ff[7] ? '0 : LW'(tlen_ff);

   always_comb begin
      sts.cmd = cmd_ff;
      sts.last = last_ff;
      sts.beyond = 32'(plen_ff) >= MAX_FRAMES;
      sts.code_big = code_big;
      sts.code_zero = code_ff == 8'd0;
      sts.slot_empty = cnt_rd == 32'd0;
      sts.len_eq = len_rd == tlen_ff;
      sts.fr_done = fi_ff >= nf;
      sts.fr_eq = st_rd == pd_rd;
      sts.probe_done = 32'(ntry_ff) >= TRACE_SLOTS - 1;
      sts.clr_done = !clearing;
   end
endmodule
